// ----- design/gascc_pkg.sv -----
// ----------------------------------------------------------------------------
// gascc_pkg
// Shared types and constants for the graph adjacency store with cycle check:
// field widths, command codes and the control bundle for the neighbour store.
// ----------------------------------------------------------------------------
package gascc_pkg;

    // Widths fixed by the item fields.
    localparam int unsigned VERT_W  = 7;
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned VCNT_W  = 8;
    localparam int unsigned ARC_W   = 15;
    localparam int unsigned HITS_W  = 14;

    localparam logic [HITS_W-1:0] HITS_MAX     = 14'd16383;
    localparam logic [VCNT_W-1:0] VCOUNT_RESET = 8'd128;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WALK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CYCLE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    // Write and clear strobes for the neighbour store and count table.
    typedef struct packed {
        logic st_wr;
        logic cnt_wr;
        logic cnt_clr;
    } gascc_mem_ctl_t;

endpackage

// ----- design/gascc_store.sv -----
// ----------------------------------------------------------------------------
// gascc_store
// Neighbour lists and per-vertex neighbour counts. The list store is a plain
// memory; the count table carries one valid bit per vertex so that a clear of
// the whole graph only has to reset those bits. Both reads are registered.
// ----------------------------------------------------------------------------
module gascc_store
    import gascc_pkg::*;
#(
    parameter int unsigned MAX_VERTS = 128
) (
    clk,
    rst_n,
    ctl,
    st_rd_addr,
    st_rd_data,
    st_wr_addr,
    st_wr_data,
    cnt_rd_idx,
    cnt_rd_data,
    cnt_wr_idx,
    cnt_wr_data
);
    localparam int unsigned DEPTH = MAX_VERTS * MAX_VERTS;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned VW    = $clog2(MAX_VERTS);
    localparam int unsigned CW    = $clog2(MAX_VERTS + 1);

    input  logic                  clk;
    input  logic                  rst_n;
    input  gascc_mem_ctl_t        ctl;
    input  logic [AW-1:0]         st_rd_addr;
    output logic [VERT_W-1:0]     st_rd_data;
    input  logic [AW-1:0]         st_wr_addr;
    input  logic [VERT_W-1:0]     st_wr_data;
    input  logic [VW-1:0]         cnt_rd_idx;
    output logic [CW-1:0]         cnt_rd_data;
    input  logic [VW-1:0]         cnt_wr_idx;
    input  logic [CW-1:0]         cnt_wr_data;

    logic [VERT_W-1:0]    st_mem [DEPTH];
    logic [CW-1:0]        cnt_mem [MAX_VERTS];
    logic [MAX_VERTS-1:0] cnt_valid_reg;
    logic [VERT_W-1:0]    st_rd_reg;
    logic [CW-1:0]        cnt_rd_reg;
    logic                 cnt_rdv_reg;

    // Neighbour list memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (ctl.st_wr)
        begin
            st_mem[st_wr_addr] <= st_wr_data;
        end
        st_rd_reg <= st_mem[st_rd_addr];
    end

    // Count memory: contents without reset, validity held in flip-flops.
    always_ff @(posedge clk)
    begin
        if (ctl.cnt_wr)
        begin
            cnt_mem[cnt_wr_idx] <= cnt_wr_data;
        end
        cnt_rd_reg <= cnt_mem[cnt_rd_idx];
    end

    // Valid bits: cleared at reset and by a graph clear, set on each write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_valid_reg <= '0;
            cnt_rdv_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.cnt_clr)
            begin
                cnt_valid_reg <= '0;
            end
            else if (ctl.cnt_wr)
            begin
                cnt_valid_reg[cnt_wr_idx] <= 1'b1;
            end
            cnt_rdv_reg <= cnt_valid_reg[cnt_rd_idx];
        end
    end

    // A count never written since the last clear reads as zero.
    assign st_rd_data  = st_rd_reg;
    assign cnt_rd_data = cnt_rdv_reg ? cnt_rd_reg : '0;

endmodule

// ----- design/graph_adjacency_store_cycle_check.sv -----
// ----------------------------------------------------------------------------
// graph_adjacency_store_cycle_check
// Directed graph store with arc insert, arc remove, walk check, graph clear and a
// depth-first cycle query, run by one sequencer over the neighbour memory.
// ----------------------------------------------------------------------------
// The block takes one command beat at a time and returns one result beat for
// each. Every list access goes through the single registered read port of the
// neighbour memory, which sets the pace: insert and walk steps read the list
// length and then scan the list one entry after another; remove then moves
// each entry behind the removed arc down by one place with a read and a write;
// a cycle query reads one list entry per arc examined and one count per vertex
// entered; clear and out-of-range commands go straight to the output step. No
// new command is taken while one is being worked on, but a command is taken
// while the previous result still waits at the output. No clearing pass runs
// after reset. The vertex_count register is written through cfg_wr_en/cfg_wr_data;
// the user must do so only while the block is idle: the block does not enforce it.
module graph_adjacency_store_cycle_check
    import gascc_pkg::*;
#(
    parameter int unsigned MAX_VERTS = 128
) (
    clk,
    rst_n,
    cfg_wr_en,
    cfg_wr_data,
    in_valid,
    in_stall,
    command,
    vertex_a,
    vertex_b,
    walk_first,
    walk_last,
    out_valid,
    out_stall,
    status,
    arc_added,
    arc_total,
    walk_valid,
    walk_arcs_found,
    cycle_found
);
    localparam int unsigned DEPTH = MAX_VERTS * MAX_VERTS;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned VW    = $clog2(MAX_VERTS);
    localparam int unsigned CW    = $clog2(MAX_VERTS + 1);
    localparam int unsigned LW    = (CW > VCNT_W) ? CW : VCNT_W;

    input  logic              clk;
    input  logic              rst_n;
    input  logic              cfg_wr_en;
    input  logic [VCNT_W-1:0] cfg_wr_data;
    input  logic              in_valid;
    output logic              in_stall;
    input  logic [CMD_W-1:0]  command;
    input  logic [VERT_W-1:0] vertex_a;
    input  logic [VERT_W-1:0] vertex_b;
    input  logic              walk_first;
    input  logic              walk_last;
    output logic              out_valid;
    input  logic              out_stall;
    output logic              status;
    output logic              arc_added;
    output logic [ARC_W-1:0]  arc_total;
    output logic              walk_valid;
    output logic [HITS_W-1:0] walk_arcs_found;
    output logic              cycle_found;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_CNTW   = 13'b0000000000010,
        ST_SCAN   = 13'b0000000000100,
        ST_RES    = 13'b0000000001000,
        ST_SHRD   = 13'b0000000010000,
        ST_SHWR   = 13'b0000000100000,
        ST_DEC    = 13'b0000001000000,
        ST_OUT    = 13'b0000010000000,
        ST_DINIT  = 13'b0000100000000,
        ST_DTOP   = 13'b0001000000000,
        ST_DNB    = 13'b0010000000000,
        ST_DPUSH  = 13'b0100000000000,
        ST_DPOP   = 13'b1000000000000
    } state_t;

    // One search frame: vertex, parent and neighbours still to be taken.
    typedef struct packed {
        logic [VERT_W-1:0] v;
        logic [VERT_W-1:0] par;
        logic              has_par;
        logic [CW-1:0]     left;
    } frame_t;

    state_t               state_reg,      state_next;
    logic [CMD_W-1:0]     cmd_reg,        cmd_next;
    logic [VERT_W-1:0]    a_reg,          a_next;
    logic [VERT_W-1:0]    key_reg,        key_next;
    logic [VERT_W-1:0]    src_reg,        src_next;
    logic                 last_reg,       last_next;
    logic                 found_reg,      found_next;
    logic [CW-1:0]        idx_reg,        idx_next;
    logic [CW-1:0]        cnt_reg,        cnt_next;
    logic [ARC_W-1:0]     arc_reg,        arc_next;
    logic [HITS_W-1:0]    hits_reg,       hits_next;
    logic                 missed_reg,     missed_next;
    logic [VERT_W-1:0]    prev_reg,       prev_next;
    logic [VCNT_W-1:0]    vcount_reg,     vcount_next;
    logic                 rstatus_reg,    rstatus_next;
    logic                 radded_reg,     radded_next;
    logic                 rwvalid_reg,    rwvalid_next;
    logic                 rcyc_reg,       rcyc_next;
    frame_t               top_reg,        top_next;
    logic [CW-1:0]        sp_reg,         sp_next;
    logic [MAX_VERTS-1:0] visited_reg,    visited_next;
    logic                 out_valid_reg,  out_valid_next;
    logic                 ostatus_reg,    ostatus_next;
    logic                 oadded_reg,     oadded_next;
    logic [ARC_W-1:0]     oarc_reg,       oarc_next;
    logic                 owvalid_reg,    owvalid_next;
    logic [HITS_W-1:0]    ohits_reg,      ohits_next;
    logic                 ocyc_reg,       ocyc_next;

    gascc_mem_ctl_t       ctl;
    logic [AW-1:0]        st_rd_addr;
    logic [VERT_W-1:0]    st_rd_data;
    logic [AW-1:0]        st_wr_addr;
    logic [VERT_W-1:0]    st_wr_data;
    logic [VW-1:0]        cnt_rd_idx;
    logic [CW-1:0]        cnt_rd_data;
    logic [VW-1:0]        cnt_wr_idx;
    logic [CW-1:0]        cnt_wr_data;

    frame_t               stk_mem [MAX_VERTS];
    frame_t               stk_rd_reg;
    logic                 stk_wr;
    logic [VW-1:0]        stk_wr_idx;
    logic [VW-1:0]        stk_rd_idx;

    logic                 accept;
    logic                 out_free;
    logic [LW-1:0]        lim;
    logic                 oob_a;
    logic                 oob_b;
    logic [AW-1:0]        base_src;
    logic [AW-1:0]        base_top;
    logic [VERT_W-1:0]    u;
    logic [VW-1:0]        u_idx;

    gascc_store #(
        .MAX_VERTS (MAX_VERTS)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .st_rd_addr  (st_rd_addr),
        .st_rd_data  (st_rd_data),
        .st_wr_addr  (st_wr_addr),
        .st_wr_data  (st_wr_data),
        .cnt_rd_idx  (cnt_rd_idx),
        .cnt_rd_data (cnt_rd_data),
        .cnt_wr_idx  (cnt_wr_idx),
        .cnt_wr_data (cnt_wr_data)
    );

    // Handshake and range checks against min(vertex_count, MAX_VERTS).
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign lim      = (LW'(vcount_reg) > LW'(MAX_VERTS)) ? LW'(MAX_VERTS) : LW'(vcount_reg);
    assign oob_a    = (LW'(vertex_a) >= lim);
    assign oob_b    = (LW'(vertex_b) >= lim);

    // Base addresses of the list being scanned and of the search frame.
    assign base_src = AW'(AW'(src_reg) * AW'(MAX_VERTS));
    assign base_top = AW'(AW'(top_reg.v) * AW'(MAX_VERTS));
    assign u        = st_rd_data;
    assign u_idx    = VW'(u);

    // Search stack: frames below the top, one write and one registered read.
    assign stk_wr_idx = VW'(sp_reg - CW'(1));
    assign stk_rd_idx = VW'(sp_reg - CW'(2));

    always_ff @(posedge clk)
    begin
        if (stk_wr)
        begin
            stk_mem[stk_wr_idx] <= top_reg;
        end
        stk_rd_reg <= stk_mem[stk_rd_idx];
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        a_next         = a_reg;
        key_next       = key_reg;
        src_next       = src_reg;
        last_next      = last_reg;
        found_next     = found_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        arc_next       = arc_reg;
        hits_next      = hits_reg;
        missed_next    = missed_reg;
        prev_next      = prev_reg;
        vcount_next    = cfg_wr_en ? cfg_wr_data : vcount_reg;
        rstatus_next   = rstatus_reg;
        radded_next    = radded_reg;
        rwvalid_next   = rwvalid_reg;
        rcyc_next      = rcyc_reg;
        top_next       = top_reg;
        sp_next        = sp_reg;
        visited_next   = visited_reg;
        out_valid_next = out_valid_reg && out_stall;
        ostatus_next   = ostatus_reg;
        oadded_next    = oadded_reg;
        oarc_next      = oarc_reg;
        owvalid_next   = owvalid_reg;
        ohits_next     = ohits_reg;
        ocyc_next      = ocyc_reg;

        ctl         = '0;
        stk_wr      = 1'b0;
        st_rd_addr  = base_src + AW'(idx_reg + CW'(1));
        st_wr_addr  = base_src + AW'(idx_reg);
        st_wr_data  = st_rd_data;
        cnt_rd_idx  = VW'(src_reg);
        cnt_wr_idx  = VW'(src_reg);
        cnt_wr_data = cnt_reg + CW'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_rd_idx = (command == CMD_WALK) ? VW'(prev_reg) : VW'(vertex_a);
                if (accept)
                begin
                    cmd_next     = command;
                    a_next       = vertex_a;
                    last_next    = walk_last;
                    rstatus_next = 1'b0;
                    radded_next  = 1'b0;
                    rwvalid_next = 1'b0;
                    rcyc_next    = 1'b0;
                    state_next   = ST_OUT;
                    unique case (command) inside
                        CMD_INSERT, CMD_REMOVE:
                        begin
                            if (oob_a || oob_b)
                            begin
                                rstatus_next = 1'b1;
                            end
                            else
                            begin
                                src_next   = vertex_a;
                                key_next   = vertex_b;
                                state_next = ST_CNTW;
                            end
                        end
                        CMD_WALK:
                        begin
                            if (oob_a)
                            begin
                                rstatus_next = 1'b1;
                            end
                            else if (walk_first)
                            begin
                                hits_next    = '0;
                                missed_next  = 1'b0;
                                prev_next    = vertex_a;
                                rwvalid_next = walk_last;
                            end
                            else
                            begin
                                src_next   = prev_reg;
                                key_next   = vertex_a;
                                state_next = ST_CNTW;
                            end
                        end
                        CMD_CYCLE:
                        begin
                            if (oob_a)
                            begin
                                rstatus_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_DINIT;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            ctl.cnt_clr = 1'b1;
                            arc_next    = '0;
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end

            // List length is back; the first entry is being read.
            ST_CNTW:
            begin
                st_rd_addr = base_src;
                cnt_next   = cnt_rd_data;
                idx_next   = '0;
                found_next = 1'b0;
                state_next = (cnt_rd_data == '0) ? ST_RES : ST_SCAN;
            end

            // Compare entry idx while the next one is read.
            ST_SCAN:
            begin
                if (st_rd_data == key_reg)
                begin
                    found_next = 1'b1;
                    state_next = ST_RES;
                end
                else if (idx_reg + CW'(1) == cnt_reg)
                begin
                    state_next = ST_RES;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            // Act on the outcome of the list scan.
            ST_RES:
            begin
                state_next = ST_OUT;
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (!found_reg && (cnt_reg < CW'(MAX_VERTS)))
                        begin
                            ctl.st_wr   = 1'b1;
                            ctl.cnt_wr  = 1'b1;
                            st_wr_addr  = base_src + AW'(cnt_reg);
                            st_wr_data  = key_reg;
                            arc_next    = arc_reg + ARC_W'(1);
                            radded_next = 1'b1;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            state_next = ST_SHRD;
                        end
                    end
                    default:
                    begin
                        // Walk step from the previous vertex.
                        if (found_reg)
                        begin
                            if (hits_reg < HITS_MAX)
                            begin
                                hits_next = hits_reg + HITS_W'(1);
                            end
                        end
                        else
                        begin
                            missed_next = 1'b1;
                        end
                        prev_next    = key_reg;
                        rwvalid_next = last_reg && !(missed_reg || !found_reg);
                    end
                endcase
            end

            // Close the gap: read entry idx + 1, then write it at idx.
            ST_SHRD:
            begin
                state_next = (idx_reg + CW'(1) < cnt_reg) ? ST_SHWR : ST_DEC;
            end

            ST_SHWR:
            begin
                ctl.st_wr  = 1'b1;
                idx_next   = idx_reg + CW'(1);
                state_next = ST_SHRD;
            end

            ST_DEC:
            begin
                ctl.cnt_wr  = 1'b1;
                cnt_wr_data = cnt_reg - CW'(1);
                if (arc_reg != '0)
                begin
                    arc_next = arc_reg - ARC_W'(1);
                end
                radded_next = 1'b1;
                state_next  = ST_OUT;
            end

            // Start frame of the search.
            ST_DINIT:
            begin
                top_next.v       = a_reg;
                top_next.par     = '0;
                top_next.has_par = 1'b0;
                top_next.left    = cnt_rd_data;
                visited_next     = '0;
                visited_next[VW'(a_reg)] = 1'b1;
                sp_next          = CW'(1);
                state_next       = ST_DTOP;
            end

            // Take the newest remaining neighbour, or leave the frame.
            ST_DTOP:
            begin
                st_rd_addr = base_top + AW'(top_reg.left - CW'(1));
                if (top_reg.left == '0)
                begin
                    if (sp_reg == CW'(1))
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        sp_next    = sp_reg - CW'(1);
                        state_next = ST_DPOP;
                    end
                end
                else
                begin
                    top_next.left = top_reg.left - CW'(1);
                    state_next    = ST_DNB;
                end
            end

            // Examine the neighbour that came back from memory.
            ST_DNB:
            begin
                cnt_rd_idx = u_idx;
                state_next = ST_DTOP;
                if (LW'(u) >= LW'(MAX_VERTS))
                begin
                    state_next = ST_DTOP;
                end
                else if (!visited_reg[u_idx])
                begin
                    visited_next[u_idx] = 1'b1;
                    if (sp_reg < CW'(MAX_VERTS))
                    begin
                        stk_wr           = 1'b1;
                        top_next.v       = u;
                        top_next.par     = top_reg.v;
                        top_next.has_par = 1'b1;
                        top_next.left    = '0;
                        sp_next          = sp_reg + CW'(1);
                        state_next       = ST_DPUSH;
                    end
                end
                else if ((!top_reg.has_par || (u != top_reg.par)) && (u == a_reg))
                begin
                    rcyc_next  = 1'b1;
                    state_next = ST_OUT;
                end
            end

            ST_DPUSH:
            begin
                top_next.left = cnt_rd_data;
                state_next    = ST_DTOP;
            end

            ST_DPOP:
            begin
                top_next   = stk_rd_reg;
                state_next = ST_DTOP;
            end

            // Hand the result to the output register once it is free.
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ostatus_next   = rstatus_reg;
                    oadded_next    = radded_reg;
                    oarc_next      = arc_reg;
                    owvalid_next   = rwvalid_reg;
                    ohits_next     = hits_reg;
                    ocyc_next      = rcyc_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= '0;
            a_reg         <= '0;
            key_reg       <= '0;
            src_reg       <= '0;
            last_reg      <= 1'b0;
            found_reg     <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            arc_reg       <= '0;
            hits_reg      <= '0;
            missed_reg    <= 1'b0;
            prev_reg      <= '0;
            vcount_reg    <= VCOUNT_RESET;
            rstatus_reg   <= 1'b0;
            radded_reg    <= 1'b0;
            rwvalid_reg   <= 1'b0;
            rcyc_reg      <= 1'b0;
            top_reg       <= '0;
            sp_reg        <= '0;
            visited_reg   <= '0;
            out_valid_reg <= 1'b0;
            ostatus_reg   <= 1'b0;
            oadded_reg    <= 1'b0;
            oarc_reg      <= '0;
            owvalid_reg   <= 1'b0;
            ohits_reg     <= '0;
            ocyc_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            a_reg         <= a_next;
            key_reg       <= key_next;
            src_reg       <= src_next;
            last_reg      <= last_next;
            found_reg     <= found_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            arc_reg       <= arc_next;
            hits_reg      <= hits_next;
            missed_reg    <= missed_next;
            prev_reg      <= prev_next;
            vcount_reg    <= vcount_next;
            rstatus_reg   <= rstatus_next;
            radded_reg    <= radded_next;
            rwvalid_reg   <= rwvalid_next;
            rcyc_reg      <= rcyc_next;
            top_reg       <= top_next;
            sp_reg        <= sp_next;
            visited_reg   <= visited_next;
            out_valid_reg <= out_valid_next;
            ostatus_reg   <= ostatus_next;
            oadded_reg    <= oadded_next;
            oarc_reg      <= oarc_next;
            owvalid_reg   <= owvalid_next;
            ohits_reg     <= ohits_next;
            ocyc_reg      <= ocyc_next;
        end
    end

    // Result beat.
    assign out_valid       = out_valid_reg;
    assign status          = ostatus_reg;
    assign arc_added       = oadded_reg;
    assign arc_total       = oarc_reg;
    assign walk_valid      = owvalid_reg;
    assign walk_arcs_found = ohits_reg;
    assign cycle_found     = ocyc_reg;

    // An accepted command always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted command did not start work");

    // A new result beat only appears after the output step of the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(state_reg == ST_OUT))
        else $error("result beat raised outside the output step");

    // The search stack never grows past one frame per vertex.
    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= CW'(MAX_VERTS))
        else $error("search stack overflow");

    // A scanned list never holds more entries than there are vertices.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ((idx_reg < cnt_reg) && (cnt_reg <= CW'(MAX_VERTS))))
        else $error("list scan index out of bounds");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the graph adjacency store with cycle check. Arc
// updates, walks and cycle queries are driven with random gaps and output
// stalls. Each result beat is compared with a software copy of the graph.
// ----------------------------------------------------------------------------
module tb;
    import gascc_pkg::*;

    localparam int unsigned NV = 128;
    localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [VERT_W-1:0] va;
        logic [VERT_W-1:0] vb;
        logic              first;
        logic              last;
    } graph_cmd_t;

    typedef struct {
        logic              status;
        logic              added;
        logic [ARC_W-1:0]  total;
        logic              wvalid;
        logic [HITS_W-1:0] hits;
        logic              cycle;
    } graph_res_t;

    // Graph model and the queue of results still owed by the block.
    class graph_scoreboard;
        logic [VERT_W-1:0] nbr [NV][NV];
        int unsigned       cnt [NV];
        int unsigned       arcs;
        int unsigned       prev;
        int unsigned       hits;
        bit                missed;
        int unsigned       limit;
        int                errors;
        graph_res_t        owed [$];

        function new();
            foreach (cnt[i]) cnt[i] = 0;
            arcs = 0;
            prev = 0;
            hits = 0;
            missed = 0;
            limit = NV;
            errors = 0;
        endfunction

        function void set_count(logic [VCNT_W-1:0] v);
            limit = (v > NV) ? NV : v;
        endfunction

        function int arc_index(int unsigned v, int unsigned w);
            for (int i = 0; i < cnt[v]; i++)
                if (nbr[v][i] == w) return i;
            return -1;
        endfunction

        // Depth-first search, newest neighbour first, for a return arc to s.
        function bit find_cycle(int unsigned s);
            bit          seen [NV];
            int unsigned fv [NV];
            int unsigned fp [NV];
            bit          fhp [NV];
            int unsigned fl [NV];
            int unsigned sp;
            int unsigned u;
            int unsigned t;
            foreach (seen[i]) seen[i] = 0;
            seen[s] = 1;
            fv[0] = s;
            fp[0] = 0;
            fhp[0] = 0;
            fl[0] = cnt[s];
            sp = 1;
            while (sp > 0) begin
                t = sp - 1;
                if (fl[t] == 0) begin
                    sp--;
                    continue;
                end
                fl[t]--;
                u = nbr[fv[t]][fl[t]];
                if (!seen[u]) begin
                    seen[u] = 1;
                    if (sp < NV) begin
                        fv[sp] = u;
                        fp[sp] = fv[t];
                        fhp[sp] = 1;
                        fl[sp] = cnt[u];
                        sp++;
                    end
                end else if ((!fhp[t] || u != fp[t]) && u == s) begin
                    return 1;
                end
            end
            return 0;
        endfunction

        // Accepted command beat: update the graph and queue the expected result.
        function void note(graph_cmd_t c);
            graph_res_t r;
            int         p;
            r = '{default: '0};
            if (c.cmd == CMD_INSERT || c.cmd == CMD_REMOVE) begin
                if (c.va >= limit || c.vb >= limit) begin
                    r.status = 1'b1;
                end else begin
                    p = arc_index(c.va, c.vb);
                    if (c.cmd == CMD_INSERT) begin
                        if (p < 0 && cnt[c.va] < NV) begin
                            nbr[c.va][cnt[c.va]] = c.vb;
                            cnt[c.va]++;
                            arcs++;
                            r.added = 1'b1;
                        end
                    end else if (p >= 0) begin
                        for (int i = p; i + 1 < cnt[c.va]; i++)
                            nbr[c.va][i] = nbr[c.va][i+1];
                        cnt[c.va]--;
                        if (arcs > 0) arcs--;
                        r.added = 1'b1;
                    end
                end
            end else if (c.cmd == CMD_WALK) begin
                if (c.va >= limit) begin
                    r.status = 1'b1;
                end else begin
                    if (c.first) begin
                        hits = 0;
                        missed = 0;
                    end else if (arc_index(prev, c.va) >= 0) begin
                        if (hits < HITS_MAX) hits++;
                    end else begin
                        missed = 1;
                    end
                    prev = c.va;
                    if (c.last) r.wvalid = !missed;
                end
            end else if (c.cmd == CMD_CYCLE) begin
                if (c.va >= limit) r.status = 1'b1;
                else r.cycle = find_cycle(c.va);
            end else if (c.cmd == CMD_CLEAR) begin
                foreach (cnt[i]) cnt[i] = 0;
                arcs = 0;
            end
            r.total = ARC_W'(arcs);
            r.hits = HITS_W'(hits);
            owed.push_back(r);
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        task check(graph_res_t g);
            graph_res_t e;
            if (owed.size() == 0) begin
                report("result beat with nothing outstanding");
                return;
            end
            e = owed.pop_front();
            if (g.status !== e.status)
                report($sformatf("status %0d, expected %0d", g.status, e.status));
            if (g.added !== e.added)
                report($sformatf("arc_added %0d, expected %0d", g.added, e.added));
            if (g.total !== e.total)
                report($sformatf("arc_total %0d, expected %0d", g.total, e.total));
            if (g.wvalid !== e.wvalid)
                report($sformatf("walk_valid %0d, expected %0d", g.wvalid, e.wvalid));
            if (g.hits !== e.hits)
                report($sformatf("walk_arcs_found %0d, expected %0d", g.hits, e.hits));
            if (g.cycle !== e.cycle)
                report($sformatf("cycle_found %0d, expected %0d", g.cycle, e.cycle));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [VCNT_W-1:0] cfg_wr_data;
    logic              in_valid;
    logic              in_stall;
    logic [CMD_W-1:0]  command;
    logic [VERT_W-1:0] vertex_a;
    logic [VERT_W-1:0] vertex_b;
    logic              walk_first;
    logic              walk_last;
    logic              out_valid;
    logic              out_stall;
    logic              status;
    logic              arc_added;
    logic [ARC_W-1:0]  arc_total;
    logic              walk_valid;
    logic [HITS_W-1:0] walk_arcs_found;
    logic              cycle_found;

    graph_scoreboard sb;
    bit              calm;

    graph_adjacency_store_cycle_check #(.MAX_VERTS(NV)) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .vertex_a        (vertex_a),
        .vertex_b        (vertex_b),
        .walk_first      (walk_first),
        .walk_last       (walk_last),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .arc_added       (arc_added),
        .arc_total       (arc_total),
        .walk_valid      (walk_valid),
        .walk_arcs_found (walk_arcs_found),
        .cycle_found     (cycle_found)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Send one command beat after a random gap; the handshake is judged at the
    // falling edge so that the rising edge sees settled values.
    task automatic send_cmd(logic [CMD_W-1:0] c, int unsigned a, int unsigned b,
                            bit f, bit l);
        graph_cmd_t it;
        bit         acc;
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.cmd = c;
        it.va = VERT_W'(a);
        it.vb = VERT_W'(b);
        it.first = f;
        it.last = l;
        in_valid <= 1'b1;
        command <= it.cmd;
        vertex_a <= it.va;
        vertex_b <= it.vb;
        walk_first <= it.first;
        walk_last <= it.last;
        do begin
            @(negedge clk);
            acc = !in_stall;
            @(posedge clk);
        end while (!acc);
        sb.note(it);
    endtask

    // Let every owed result arrive before the vertex count is changed.
    task automatic set_vertex_count(logic [VCNT_W-1:0] v);
        in_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_count(v);
    endtask

    function automatic int unsigned pick_vertex();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, NV - 1);
        return $urandom_range(0, sb.limit - 1);
    endfunction

    // A walk that mostly follows stored arcs, sometimes strays.
    task automatic send_walk();
        int unsigned len;
        int unsigned v;
        len = $urandom_range(1, 6);
        v = pick_vertex();
        for (int i = 0; i < len; i++) begin
            if (i > 0) begin
                if (v < NV && sb.cnt[v] > 0 && $urandom_range(0, 9) < 8)
                    v = sb.nbr[v][$urandom_range(0, sb.cnt[v] - 1)];
                else
                    v = pick_vertex();
            end
            send_cmd(CMD_WALK, v, $urandom_range(0, NV - 1), i == 0, i == len - 1);
        end
    endtask

    task automatic send_random();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 38)
            send_cmd(CMD_INSERT, pick_vertex(), pick_vertex(), 1'($urandom), 1'($urandom));
        else if (k < 53)
            send_cmd(CMD_REMOVE, pick_vertex(), pick_vertex(), 1'($urandom), 1'($urandom));
        else if (k < 73)
            send_walk();
        else if (k < 78)
            send_cmd(CMD_WALK, pick_vertex(), $urandom, 1'($urandom), 1'($urandom));
        else if (k < 95)
            send_cmd(CMD_CYCLE, pick_vertex(), $urandom, 1'($urandom), 1'($urandom));
        else if (k < 97)
            send_cmd(CMD_CLEAR, $urandom, $urandom, 1'($urandom), 1'($urandom));
        else
            send_cmd(CMD_W'($urandom_range(CMD_SPARE_5, CMD_SPARE_7)), $urandom, $urandom,
                     1'($urandom), 1'($urandom));
    endtask

    // Result side: random stalls, then check the beat taken.
    initial begin
        graph_res_t g;
        bit         acc;
        int unsigned hold;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever begin
            hold = calm ? 0 : $urandom_range(0, 6);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do begin
                @(negedge clk);
                acc = out_valid;
                g.status = status;
                g.added = arc_added;
                g.total = arc_total;
                g.wvalid = walk_valid;
                g.hits = walk_arcs_found;
                g.cycle = cycle_found;
                @(posedge clk);
            end while (!acc);
            sb.check(g);
        end
    end

    // Timeout guard.
    initial begin
        #200ms;
        $display("CHECK FAILED");
        $finish;
    end

    // Main sequence: reset, directed cases, then random phases.
    initial begin
        logic [VCNT_W-1:0] counts [7];
        sb = new();
        calm = 0;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        in_valid <= 1'b0;
        command <= CMD_INSERT;
        vertex_a <= '0;
        vertex_b <= '0;
        walk_first <= 1'b0;
        walk_last <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases at the reset vertex count.
        send_cmd(CMD_WALK, 127, 0, 0, 0);
        send_cmd(CMD_INSERT, 0, 127, 0, 0);
        send_cmd(CMD_INSERT, 127, 0, 1, 1);
        send_cmd(CMD_INSERT, 0, 127, 0, 0);
        send_cmd(CMD_CYCLE, 0, 0, 0, 0);
        send_cmd(CMD_INSERT, 5, 5, 0, 0);
        send_cmd(CMD_CYCLE, 5, 0, 0, 0);
        send_cmd(CMD_WALK, 0, 0, 1, 1);
        send_cmd(CMD_WALK, 127, 0, 1, 0);
        send_cmd(CMD_WALK, 0, 0, 0, 0);
        send_cmd(CMD_WALK, 5, 0, 0, 1);
        send_cmd(CMD_REMOVE, 0, 127, 0, 0);
        send_cmd(CMD_REMOVE, 0, 127, 0, 0);
        send_cmd(CMD_SPARE_5, 127, 127, 1, 1);
        send_cmd(CMD_SPARE_7, 0, 0, 0, 0);
        send_cmd(CMD_CLEAR, 0, 0, 0, 0);
        send_cmd(CMD_CYCLE, 127, 0, 0, 0);

        // Vertex count of one: everything but vertex 0 is out of range.
        set_vertex_count(8'd1);
        send_cmd(CMD_INSERT, 0, 0, 0, 0);
        send_cmd(CMD_INSERT, 0, 1, 0, 0);
        send_cmd(CMD_REMOVE, 1, 0, 0, 0);
        send_cmd(CMD_WALK, 1, 0, 1, 1);
        send_cmd(CMD_CYCLE, 1, 0, 0, 0);
        send_cmd(CMD_CYCLE, 0, 0, 0, 0);

        counts = '{8'd8, 8'd255, 8'd3, 8'd40, 8'd128, 8'd1, 8'd16};
        foreach (counts[p]) begin
            set_vertex_count(counts[p]);
            for (int n = 0; n < 85; n++) begin
                if (n % 40 == 0) calm = ($urandom_range(0, 2) == 0);
                send_random();
            end
        end
        calm = 0;
        in_valid <= 1'b0;

        while (sb.owed.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
